// File: design/mkrs_pkg.sv
// mkrs_pkg: shared constants, record type and key compare for the record sorter
// depends on nothing; used by the interfaces, the cell, the chain and the top level
package mkrs_pkg;

   localparam int MAX_RECORDS = 64;
   localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
   localparam int POS_W       = 6;
   localparam int ENG_W       = 7;
   localparam int MATH_W      = 7;
   localparam int ID_W        = 30;
   localparam int CLASS_W     = 4;
   localparam int SEC_W       = 5;

   typedef struct packed {
      logic [POS_W-1:0]   pos;
      logic [ENG_W-1:0]   eng;
      logic [MATH_W-1:0]  math;
      logic [ID_W-1:0]    id;
      logic [CLASS_W-1:0] cls;
      logic [SEC_W-1:0]   sec;
   } rec_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   // true when a sorts strictly ahead of b
   function automatic logic goes_before(input rec_type a, input rec_type b);
      logic res;
      if (a.eng != b.eng) begin
         res = (a.eng > b.eng);
      end else if (a.math != b.math) begin
         res = (a.math > b.math);
      end else begin
         res = (a.id < b.id);
      end
      return res;
   endfunction

endpackage

// File: design/mkrs_if.sv
// mkrs_req_if / mkrs_rsp_if: valid-ready channels for records in and sorted records out
// depends on mkrs_pkg for field widths
interface mkrs_req_if;
   logic                           valid;
   logic                           ready;
   logic [mkrs_pkg::ENG_W-1:0]     eng_mark;
   logic [mkrs_pkg::MATH_W-1:0]    math_mark;
   logic [mkrs_pkg::ID_W-1:0]      student_id;
   logic [mkrs_pkg::CLASS_W-1:0]   class_num;
   logic [mkrs_pkg::SEC_W-1:0]     section_letter;
   logic                           last_record;

   modport source (output valid, eng_mark, math_mark, student_id, class_num,
                   section_letter, last_record, input ready);
   modport sink   (input valid, eng_mark, math_mark, student_id, class_num,
                   section_letter, last_record, output ready);
endinterface

interface mkrs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mkrs_pkg::POS_W-1:0]     load_position;
   logic [mkrs_pkg::ENG_W-1:0]     out_eng;
   logic [mkrs_pkg::MATH_W-1:0]    out_math;
   logic [mkrs_pkg::ID_W-1:0]      out_id;
   logic [mkrs_pkg::CLASS_W-1:0]   out_class;
   logic [mkrs_pkg::SEC_W-1:0]     out_section;
   logic                           overflow;
   logic                           end_of_run;

   modport source (output valid, load_position, out_eng, out_math, out_id, out_class,
                   out_section, overflow, end_of_run, input ready);
   modport sink   (input valid, load_position, out_eng, out_math, out_id, out_class,
                   out_section, overflow, end_of_run, output ready);
endinterface

// File: design/mkrs_cell.sv
// mkrs_cell: one slot of the sorted chain, holds a record and its valid bit
// depends on mkrs_pkg (rec_type, cell_ctrl_type, goes_before)
module mkrs_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  mkrs_pkg::cell_ctrl_type ctrl,
   input  mkrs_pkg::rec_type       new_rec,
   input  mkrs_pkg::rec_type       left_rec,
   input  logic                    left_valid,
   input  logic                    left_ins,
   input  mkrs_pkg::rec_type       right_rec,
   input  logic                    right_valid,
   output mkrs_pkg::rec_type       rec,
   output logic                    valid,
   output logic                    ins
);

   mkrs_pkg::rec_type rec_ff, rec_in;
   logic              valid_ff, valid_in;

   // empty slots always yield to the incoming record
   assign ins = !valid_ff || mkrs_pkg::goes_before(new_rec, rec_ff);

   always_comb begin
      rec_in   = rec_ff;
      valid_in = valid_ff;
      if (ctrl.insert && ins) begin
         if (left_ins) begin
            rec_in   = left_rec;
            valid_in = left_valid;
         end else begin
            rec_in   = new_rec;
            valid_in = 1'b1;
         end
      end else if (ctrl.shift) begin
         rec_in   = right_rec;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rec   = rec_ff;
   assign valid = valid_ff;

endmodule

// File: design/mkrs_chain.sv
// mkrs_chain: row of mkrs_cell slots kept in sorted order, head at slot 0
// depends on mkrs_pkg and mkrs_cell
module mkrs_chain (
   input  logic                    clock,
   input  logic                    reset,
   input  mkrs_pkg::cell_ctrl_type ctrl,
   input  mkrs_pkg::rec_type       new_rec,
   output mkrs_pkg::rec_type       head_rec
);

   mkrs_pkg::rec_type recs   [mkrs_pkg::MAX_RECORDS];
   logic              valids [mkrs_pkg::MAX_RECORDS];
   logic              inss   [mkrs_pkg::MAX_RECORDS];

   genvar i;
   generate
      for (i = 0; i < mkrs_pkg::MAX_RECORDS; i++) begin : g_cell
         mkrs_pkg::rec_type l_rec, r_rec;
         logic              l_valid, l_ins, r_valid;

         if (i == 0) begin : g_head
            assign l_rec   = new_rec;
            assign l_valid = 1'b0;
            assign l_ins   = 1'b0;
         end else begin : g_mid
            assign l_rec   = recs[i-1];
            assign l_valid = valids[i-1];
            assign l_ins   = inss[i-1];
         end

         if (i == mkrs_pkg::MAX_RECORDS - 1) begin : g_tail
            assign r_rec   = new_rec;
            assign r_valid = 1'b0;
         end else begin : g_body
            assign r_rec   = recs[i+1];
            assign r_valid = valids[i+1];
         end

         mkrs_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .new_rec     (new_rec),
            .left_rec    (l_rec),
            .left_valid  (l_valid),
            .left_ins    (l_ins),
            .right_rec   (r_rec),
            .right_valid (r_valid),
            .rec         (recs[i]),
            .valid       (valids[i]),
            .ins         (inss[i])
         );
      end
   endgenerate

   assign head_rec = recs[0];

endmodule

// File: design/multi_key_record_sorter.sv
// multi_key_record_sorter: streaming insertion sorter over a chain of record cells
// depends on mkrs_pkg, mkrs_if (mkrs_req_if, mkrs_rsp_if) and mkrs_chain
//
//   channel | dir | handshake           | item
//   --------+-----+---------------------+-------------------------------------------
//   req_ch  | in  | valid/ready         | one record, last_record closes the set
//   rsp_ch  | out | valid/ready, reg'd  | one sorted record, end_of_run on the last
//
// while loading, one record is taken per cycle: every cell compares the broadcast
// record with its own in parallel and the chain opens a gap in that same cycle
// after the last record of a set, the chain drains one record per cycle from its
// head through the output register; no input item is taken during the drain,
// and stalls on rsp_ch hold the drain
// synchronous active-high reset empties the chain and clears count and flag
module multi_key_record_sorter (
   input  logic       clock,
   input  logic       reset,
   mkrs_req_if.sink   req_ch,
   mkrs_rsp_if.source rsp_ch
);

   mkrs_pkg::state_type         state_ff, state_in;
   logic [mkrs_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                        dropped_ff, dropped_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   mkrs_pkg::rec_type           rsp_rec_ff, rsp_rec_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;
   logic                        rsp_end_ff, rsp_end_in;

   mkrs_pkg::cell_ctrl_type     ctrl;
   mkrs_pkg::rec_type           new_rec;
   mkrs_pkg::rec_type           head_rec;
   logic                        accept;
   logic                        full;
   logic                        pop;

   // incoming record, tagged with its load position (low bits of the count)
   always_comb begin
      new_rec.pos  = mkrs_pkg::POS_W'(count_ff);
      new_rec.eng  = req_ch.eng_mark;
      new_rec.math = req_ch.math_mark;
      new_rec.id   = req_ch.student_id;
      new_rec.cls  = req_ch.class_num;
      new_rec.sec  = req_ch.section_letter;
   end

   assign req_ch.ready = (state_ff == mkrs_pkg::ST_LOAD);
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = (count_ff == mkrs_pkg::CNT_W'(mkrs_pkg::MAX_RECORDS));

   // drain steps whenever the output register is free or being emptied
   assign pop = (state_ff == mkrs_pkg::ST_DRAIN) && (!rsp_valid_ff || rsp_ch.ready);

   assign ctrl.insert = accept && !full;
   assign ctrl.shift  = pop;

   mkrs_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .new_rec  (new_rec),
      .head_rec (head_rec)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_rec_in   = rsp_rec_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_end_in   = rsp_end_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         mkrs_pkg::ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
               // the set always holds at least one record once closed
               if (req_ch.last_record) begin
                  state_in = mkrs_pkg::ST_DRAIN;
               end
            end
         end
         mkrs_pkg::ST_DRAIN: begin
            if (pop) begin
               rsp_valid_in = 1'b1;
               rsp_rec_in   = head_rec;
               rsp_ovf_in   = dropped_ff;
               rsp_end_in   = (count_ff == mkrs_pkg::CNT_W'(1));
               count_in     = count_ff - 1'b1;
               if (count_ff == mkrs_pkg::CNT_W'(1)) begin
                  state_in   = mkrs_pkg::ST_LOAD;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = mkrs_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_rec_ff <= rsp_rec_in;
      rsp_ovf_ff <= rsp_ovf_in;
      rsp_end_ff <= rsp_end_in;
      if (reset) begin
         state_ff     <= mkrs_pkg::ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.load_position = rsp_rec_ff.pos;
   assign rsp_ch.out_eng       = rsp_rec_ff.eng;
   assign rsp_ch.out_math      = rsp_rec_ff.math;
   assign rsp_ch.out_id        = rsp_rec_ff.id;
   assign rsp_ch.out_class     = rsp_rec_ff.cls;
   assign rsp_ch.out_section   = rsp_rec_ff.sec;
   assign rsp_ch.overflow      = rsp_ovf_ff;
   assign rsp_ch.end_of_run    = rsp_end_ff;

endmodule

// File: tb/sv/record_order_checker.sv
// record_order_checker: watches both channels of the record sorter, predicts each sorted run
// and compares every result field by field; depends on mkrs_pkg and mkrs_req_if / mkrs_rsp_if
module record_order_checker (
   input  logic clock,
   input  logic reset,
   mkrs_req_if  req_ch,
   mkrs_rsp_if  rsp_ch,
   output int   fail_count,
   output int   awaiting
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      mkrs_pkg::rec_type rec;
      logic              overflow;
      logic              end_of_run;
   } sorted_out_type;

   mkrs_pkg::rec_type ranked[$];   // records of the open set, best first
   sorted_out_type    due[$];      // sorted results still to come
   logic              set_dropped = 1'b0;
   int                mismatches = 0;
   int                due_count = 0;

   assign fail_count = mismatches;
   assign awaiting   = due_count;

   // ids ascend, so the inverted id lets the larger key win at every level
   function automatic bit ranks_ahead(input mkrs_pkg::rec_type a, input mkrs_pkg::rec_type b);
      return {a.eng, a.math, ~a.id} > {b.eng, b.math, ~b.id};
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      sorted_out_type    want;
      mkrs_pkg::rec_type rec;
      int unsigned       slot;
      int unsigned       k;
      if (reset) begin
         ranked.delete();
         due.delete();
         set_dropped = 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due.size() == 0) begin
               $error("sorted item with id %0d arrived with nothing expected", rsp_ch.out_id);
               mismatches++;
            end else begin
               want = due.pop_front();
               check_field("load_position", want.rec.pos, rsp_ch.load_position);
               check_field("out_eng", want.rec.eng, rsp_ch.out_eng);
               check_field("out_math", want.rec.math, rsp_ch.out_math);
               check_field("out_id", want.rec.id, rsp_ch.out_id);
               check_field("out_class", want.rec.cls, rsp_ch.out_class);
               check_field("out_section", want.rec.sec, rsp_ch.out_section);
               check_field("overflow", want.overflow, rsp_ch.overflow);
               check_field("end_of_run", want.end_of_run, rsp_ch.end_of_run);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            rec.pos  = mkrs_pkg::POS_W'(ranked.size());
            rec.eng  = req_ch.eng_mark;
            rec.math = req_ch.math_mark;
            rec.id   = req_ch.student_id;
            rec.cls  = req_ch.class_num;
            rec.sec  = req_ch.section_letter;
            if (ranked.size() < mkrs_pkg::MAX_RECORDS) begin
               ranked.push_back(rec);
               // move forward past every record it strictly outranks, full ties stay behind
               slot = ranked.size() - 1;
               while (slot > 0 && ranks_ahead(ranked[slot], ranked[slot-1])) begin
                  rec              = ranked[slot-1];
                  ranked[slot-1]   = ranked[slot];
                  ranked[slot]     = rec;
                  slot--;
               end
            end else begin
               set_dropped = 1'b1;
            end
            if (req_ch.last_record) begin
               for (k = 0; k < ranked.size(); k++) begin
                  want.rec        = ranked[k];
                  want.overflow   = set_dropped;
                  want.end_of_run = (k + 1 == ranked.size());
                  due.push_back(want);
               end
               ranked.delete();
               set_dropped = 1'b0;
            end
         end
      end
      due_count = due.size();
   end

endmodule

// File: tb/sv/tb_top.sv
// tb_top: clock, reset and stimulus for multi_key_record_sorter, with the verdict at the end
// depends on mkrs_pkg, mkrs_if, the sorter rtl and record_order_checker
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
   localparam int HOLD_CYCLES  = 300;     // long receiver stall that backs up the input
   localparam int DRAIN_CYCLES = 20;      // quiet cycles after the last expected item

   logic clock;
   logic reset;
   int   fail_count;
   int   awaiting;
   int   cycle_count = 0;

   // idle chances in percent, written only by the stimulus process
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   // each bump asks the receiver for one long hold-off
   int unsigned hold_asks = 0;

   mkrs_req_if req_ch ();
   mkrs_rsp_if rsp_ch ();

   multi_key_record_sorter u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   record_order_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .awaiting   (awaiting)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog against a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: random back-pressure, plus the long hold-off when asked
   initial begin
      int unsigned served;
      int unsigned held;
      served = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != served) begin
            served++;
            rsp_ch.ready <= 1'b0;
            // count the stall here, ready stays low throughout
            for (held = 1; held < HOLD_CYCLES; held++) begin
               @(negedge clock);
            end
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // offer one record, idling first at random, and return at the negedge after acceptance
   task automatic push_record(input logic [mkrs_pkg::ENG_W-1:0] eng,
                              input logic [mkrs_pkg::MATH_W-1:0] math,
                              input logic [mkrs_pkg::ID_W-1:0] id,
                              input logic [mkrs_pkg::CLASS_W-1:0] cls,
                              input logic [mkrs_pkg::SEC_W-1:0] sec, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.eng_mark       <= eng;
      req_ch.math_mark      <= math;
      req_ch.student_id     <= id;
      req_ch.class_num      <= cls;
      req_ch.section_letter <= sec;
      req_ch.last_record    <= last;
      req_ch.valid          <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // random sets until the phase has offered its share of items; the first set size is given
   task automatic run_phase(input int unsigned quota, input int unsigned opening_size);
      int unsigned sent;
      int unsigned set_size;
      int unsigned k;
      int unsigned mode;
      int unsigned pick;
      bit          dense;
      logic [mkrs_pkg::ENG_W-1:0]   eng;
      logic [mkrs_pkg::MATH_W-1:0]  math;
      logic [mkrs_pkg::ID_W-1:0]    id;
      logic [mkrs_pkg::CLASS_W-1:0] cls;
      logic [mkrs_pkg::SEC_W-1:0]   sec;
      sent = 0;
      set_size = opening_size;
      while (sent < quota) begin
         // dense sets crowd the keys together so ties on every level show up
         dense = ($urandom_range(99) < 30);
         for (k = 0; k < set_size; k++) begin
            mode = $urandom_range(99);
            if (mode < 10) begin
               // noise: raw bits over the whole field widths
               eng  = mkrs_pkg::ENG_W'($urandom);
               math = mkrs_pkg::MATH_W'($urandom);
               id   = mkrs_pkg::ID_W'($urandom);
               cls  = mkrs_pkg::CLASS_W'($urandom);
               sec  = mkrs_pkg::SEC_W'($urandom);
            end else if (dense) begin
               eng  = mkrs_pkg::ENG_W'($urandom_range(97, 100));
               math = mkrs_pkg::MATH_W'($urandom_range(98, 100));
               id   = mkrs_pkg::ID_W'($urandom_range(1, 6));
               cls  = mkrs_pkg::CLASS_W'($urandom_range(1, 10));
               sec  = mkrs_pkg::SEC_W'($urandom_range(0, 25));
            end else begin
               eng  = mkrs_pkg::ENG_W'($urandom_range(0, 100));
               math = mkrs_pkg::MATH_W'($urandom_range(0, 100));
               id   = mkrs_pkg::ID_W'($urandom_range(1, 1000000000));
               cls  = mkrs_pkg::CLASS_W'($urandom_range(1, 10));
               sec  = mkrs_pkg::SEC_W'($urandom_range(0, 25));
            end
            push_record(eng, math, id, cls, sec, k == set_size - 1);
         end
         sent += set_size;
         // mostly small sets, some medium, a few near or past capacity
         pick = $urandom_range(99);
         if (pick < 70) begin
            set_size = $urandom_range(1, 8);
         end else if (pick < 90) begin
            set_size = $urandom_range(9, 32);
         end else begin
            set_size = $urandom_range(mkrs_pkg::MAX_RECORDS - 4, mkrs_pkg::MAX_RECORDS + 6);
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      reset = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.eng_mark       = '0;
      req_ch.math_mark      = '0;
      req_ch.student_id     = '0;
      req_ch.class_num      = '0;
      req_ch.section_letter = '0;
      req_ch.last_record    = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      send_idle_pct = 12;
      recv_idle_pct = 51;

      // single-record sets with every field at all ones, then all zeros
      push_record(7'h7f, 7'h7f, 30'h3fffffff, 4'hf, 5'h1f, 1'b1);
      push_record(7'd0, 7'd0, 30'd0, 4'd0, 5'd0, 1'b1);

      // ties at each key level, full ties keep load order
      push_record(7'd90, 7'd50, 30'd300, 4'd1, 5'd0, 1'b0);
      push_record(7'd90, 7'd60, 30'd500, 4'd2, 5'd1, 1'b0);   // higher math goes first
      push_record(7'd90, 7'd60, 30'd400, 4'd3, 5'd2, 1'b0);   // lower id goes first
      push_record(7'd95, 7'd10, 30'd900, 4'd4, 5'd3, 1'b0);   // higher english goes ahead of the 90s
      push_record(7'd90, 7'd60, 30'd400, 4'd5, 5'd4, 1'b0);   // full tie, lands after
      push_record(7'd90, 7'd60, 30'd400, 4'd6, 5'd5, 1'b0);   // another full tie
      push_record(7'd0, 7'd100, 30'd1, 4'd7, 5'd6, 1'b0);
      push_record(7'd100, 7'd0, 30'd1000000000, 4'd10, 5'd25, 1'b1);

      // ascending arrival: every record moves to the front
      push_record(7'd10, 7'd40, 30'd11, 4'd1, 5'd7, 1'b0);
      push_record(7'd20, 7'd30, 30'd12, 4'd2, 5'd8, 1'b0);
      push_record(7'd30, 7'd20, 30'd13, 4'd3, 5'd9, 1'b0);
      push_record(7'd40, 7'd10, 30'd14, 4'd4, 5'd10, 1'b0);
      push_record(7'd50, 7'd0, 30'd15, 4'd5, 5'd11, 1'b1);

      // already sorted arrival at the in-range extremes
      push_record(7'd100, 7'd100, 30'd1, 4'd10, 5'd25, 1'b0);
      push_record(7'd100, 7'd100, 30'd2, 4'd1, 5'd0, 1'b0);
      push_record(7'd100, 7'd99, 30'd1, 4'd9, 5'd24, 1'b0);
      push_record(7'd0, 7'd0, 30'd1000000000, 4'd1, 5'd0, 1'b1);

      // opens with a set past capacity whose last two records are dropped
      run_phase(130, mkrs_pkg::MAX_RECORDS + 2);

      // sender idles heavily, receiver lightly; opens with an exactly full set
      send_idle_pct = 51;
      recv_idle_pct = 12;
      run_phase(130, mkrs_pkg::MAX_RECORDS);

      // no idling; a long receiver hold-off backs the block up into its input
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_asks++;
      run_phase(140, mkrs_pkg::MAX_RECORDS + 1);
      req_ch.valid <= 1'b0;

      while (awaiting != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: multi_key_record_sorter.f
design/mkrs_pkg.sv
design/mkrs_if.sv
design/mkrs_cell.sv
design/mkrs_chain.sv
design/multi_key_record_sorter.sv
tb/sv/record_order_checker.sv
tb/sv/tb_top.sv
